/* sv/dfrt_pkg.sv */
// Package for the dipole field rotate and translate block.
// Holds the output field width, the output stream width and the ratio lane codes.
// Used by every module of the block; depends on nothing else.
package dfrt_pkg;

  // Result fields are signed Q26.0 integers whatever the input width.
  localparam int OUT_W  = 26;
  localparam int N_OUT  = 6;
  localparam int OUT_TD = ((N_OUT * OUT_W + 7) / 8) * 8;

  // Input fields per item.
  localparam int N_IN = 12;

  // Lanes of the divider chain: cos and sin of the polar angle, then of the azimuth.
  localparam int N_RATIO = 4;
  localparam int RT_CT   = 0;
  localparam int RT_ST   = 1;
  localparam int RT_CP   = 2;
  localparam int RT_SP   = 3;

  // Per-lane flags that travel beside the quotient.
  typedef struct packed {
    logic zero;  // denominator was zero, the lane takes its fixed value
    logic neg;   // numerator was negative
  } ratio_flag_t;

endpackage

/* sv/dfrt_sqrt_cell.sv */
// One cell of the square root chain: resolves one root bit of both norms.
// Depends on dfrt_pkg.
module dfrt_sqrt_cell
  import dfrt_pkg::*;
#(
  parameter int SW     = 48,
  parameter int STEP   = 0,
  parameter int SIDE_W = 288
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [SW-1:0]     n_xy_i,
  input  logic [SW-1:0]     r_xy_i,
  input  logic [SW-1:0]     n_all_i,
  input  logic [SW-1:0]     r_all_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SW-1:0]     n_xy_o,
  output logic [SW-1:0]     r_xy_o,
  output logic [SW-1:0]     n_all_o,
  output logic [SW-1:0]     r_all_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [SW-1:0] BIT = {{(SW-1){1'b0}}, 1'b1} << (SW - 2 - 2 * STEP);

  logic              v_q;
  logic [SW-1:0]     n_xy_q, r_xy_q, n_all_q, r_all_q;
  logic [SW-1:0]     n_xy_d, r_xy_d, n_all_d, r_all_d;
  logic [SIDE_W-1:0] side_q;

  // One step of the digit-by-digit square root: {remainder, root}.
  function automatic logic [2*SW-1:0] sq_step(logic [SW-1:0] n, logic [SW-1:0] r);
    logic [SW-1:0] t;
    t = r + BIT;
    if (n >= t) begin
      return {n - t, (r >> 1) + BIT};
    end else begin
      return {n, r >> 1};
    end
  endfunction

  assign in_ready_o = !v_q || out_ready_i;

  always_comb begin
    {n_xy_d, r_xy_d}   = sq_step(n_xy_i, r_xy_i);
    {n_all_d, r_all_d} = sq_step(n_all_i, r_all_i);
  end

  // Valid flag of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  // Working values move on whenever the cell can take a new transfer.
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      n_xy_q  <= n_xy_d;
      r_xy_q  <= r_xy_d;
      n_all_q <= n_all_d;
      r_all_q <= r_all_d;
      side_q  <= side_i;
    end
  end

  assign out_valid_o = v_q;
  assign n_xy_o      = n_xy_q;
  assign r_xy_o      = r_xy_q;
  assign n_all_o     = n_all_q;
  assign r_all_o     = r_all_q;
  assign side_o      = side_q;

endmodule

/* sv/dfrt_div_cell.sv */
// One cell of the divider chain: resolves one quotient bit of all four ratios.
// Depends on dfrt_pkg.
module dfrt_div_cell
  import dfrt_pkg::*;
#(
  parameter int DV     = 41,
  parameter int QW     = 17,
  parameter int J      = 16,
  parameter int SIDE_W = 224
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DV-1:0]     rem_i [N_RATIO],
  input  logic [DV-1:0]     den_i [N_RATIO],
  input  logic [QW-1:0]     q_i   [N_RATIO],
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DV-1:0]     rem_o [N_RATIO],
  output logic [DV-1:0]     den_o [N_RATIO],
  output logic [QW-1:0]     q_o   [N_RATIO],
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q;
  logic [DV-1:0]     rem_q [N_RATIO];
  logic [DV-1:0]     den_q [N_RATIO];
  logic [QW-1:0]     q_q   [N_RATIO];
  logic [DV-1:0]     rem_d [N_RATIO];
  logic [QW-1:0]     q_d   [N_RATIO];
  logic [SIDE_W-1:0] side_q;

  assign in_ready_o = !v_q || out_ready_i;

  // Restoring division step: subtract the shifted divisor where it fits.
  always_comb begin
    for (int i = 0; i < N_RATIO; i++) begin
      if (rem_i[i] >= (den_i[i] << J)) begin
        rem_d[i] = rem_i[i] - (den_i[i] << J);
        q_d[i]   = q_i[i] | (QW'(1) << J);
      end else begin
        rem_d[i] = rem_i[i];
        q_d[i]   = q_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      for (int i = 0; i < N_RATIO; i++) begin
        rem_q[i] <= rem_d[i];
        den_q[i] <= den_i[i];
        q_q[i]   <= q_d[i];
      end
      side_q <= side_i;
    end
  end

  assign out_valid_o = v_q;
  assign rem_o       = rem_q;
  assign den_o       = den_q;
  assign q_o         = q_q;
  assign side_o      = side_q;

endmodule

/* sv/dfrt_rotator.sv */
// Four-stage rotation and translation of the E and H vectors by Rz*Ry.
// Depends on dfrt_pkg.
module dfrt_rotator
  import dfrt_pkg::*;
#(
  parameter int W = 24,
  parameter int F = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [F+1:0]   ct_i,
  input  logic signed [F+1:0]   st_i,
  input  logic signed [F+1:0]   cp_i,
  input  logic signed [F+1:0]   sp_i,
  input  logic [9*W-1:0]        rest_i,   // pos x,y,z, e x,y,z, h x,y,z from bit 0
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_TD-1:0]     out_data_o
);

  localparam int CW = F + 2;
  localparam int PW = W + CW;
  localparam int AW = PW + 1;
  localparam int MW = AW + CW;
  localparam int EW = MW + 2;

  logic [3:0] v_q;
  logic [3:0] rdy;

  // Stage 1: products of the polar rotation.
  logic signed [PW-1:0] s1_pa_q [2], s1_pb_q [2], s1_pc_q [2], s1_pd_q [2];
  logic signed [W-1:0]  s1_vy_q [2];
  logic signed [CW-1:0] s1_cp_q, s1_sp_q;
  logic signed [W-1:0]  s1_pos_q [3];
  // Stage 2: rotated about y.
  logic signed [AW-1:0] s2_a_q [2], s2_b_q [2], s2_c_q [2];
  logic signed [CW-1:0] s2_cp_q, s2_sp_q;
  logic signed [W-1:0]  s2_pos_q [3];
  // Stage 3: products of the azimuth rotation.
  logic signed [MW-1:0] s3_m1_q [2], s3_m2_q [2], s3_m3_q [2], s3_m4_q [2];
  logic signed [AW-1:0] s3_c_q [2];
  logic signed [W-1:0]  s3_pos_q [3];
  // Stage 4: rounded and translated result.
  logic [OUT_TD-1:0]    out_q;
  logic [OUT_TD-1:0]    out_d;

  logic signed [W-1:0]  vx [2], vy [2], vz [2], pos [3];
  logic signed [EW-1:0] xr, yr, zr, res;

  assign rdy[3]     = !v_q[3] || out_ready_i;
  assign rdy[2]     = !v_q[2] || rdy[3];
  assign rdy[1]     = !v_q[1] || rdy[2];
  assign rdy[0]     = !v_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  // Unpack the vectors of the incoming transfer.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos[k] = signed'(rest_i[k*W +: W]);
    end
    for (int f = 0; f < 2; f++) begin
      vx[f] = signed'(rest_i[(3+3*f)*W +: W]);
      vy[f] = signed'(rest_i[(4+3*f)*W +: W]);
      vz[f] = signed'(rest_i[(5+3*f)*W +: W]);
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int f = 0; f < 2; f++) begin
        s1_pa_q[f] <= PW'(ct_i) * PW'(vx[f]);
        s1_pb_q[f] <= PW'(st_i) * PW'(vz[f]);
        s1_pc_q[f] <= PW'(ct_i) * PW'(vz[f]);
        s1_pd_q[f] <= PW'(st_i) * PW'(vx[f]);
        s1_vy_q[f] <= vy[f];
      end
      s1_cp_q  <= cp_i;
      s1_sp_q  <= sp_i;
      s1_pos_q <= pos;
    end
  end

  // Stage 2 registers.
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int f = 0; f < 2; f++) begin
        s2_a_q[f] <= AW'(s1_pa_q[f]) + AW'(s1_pb_q[f]);
        s2_c_q[f] <= AW'(s1_pc_q[f]) - AW'(s1_pd_q[f]);
        s2_b_q[f] <= AW'(s1_vy_q[f]) <<< F;
      end
      s2_cp_q  <= s1_cp_q;
      s2_sp_q  <= s1_sp_q;
      s2_pos_q <= s1_pos_q;
    end
  end

  // Stage 3 registers.
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int f = 0; f < 2; f++) begin
        s3_m1_q[f] <= MW'(s2_cp_q) * MW'(s2_a_q[f]);
        s3_m2_q[f] <= MW'(s2_sp_q) * MW'(s2_b_q[f]);
        s3_m3_q[f] <= MW'(s2_sp_q) * MW'(s2_a_q[f]);
        s3_m4_q[f] <= MW'(s2_cp_q) * MW'(s2_b_q[f]);
        s3_c_q[f]  <= s2_c_q[f];
      end
      s3_pos_q <= s2_pos_q;
    end
  end

  // Stage 4: round half up, subtract the position and pack the result fields.
  always_comb begin
    out_d = '0;
    for (int f = 0; f < 2; f++) begin
      xr  = (EW'(s3_m1_q[f]) - EW'(s3_m2_q[f]) + (EW'(1) <<< (2*F-1))) >>> (2*F);
      yr  = (EW'(s3_m3_q[f]) + EW'(s3_m4_q[f]) + (EW'(1) <<< (2*F-1))) >>> (2*F);
      zr  = (EW'(s3_c_q[f]) + (EW'(1) <<< (F-1))) >>> F;
      res = xr - EW'(s3_pos_q[0]);
      out_d[(3*f)*OUT_W +: OUT_W] = res[OUT_W-1:0];
      res = yr - EW'(s3_pos_q[1]);
      out_d[(3*f+1)*OUT_W +: OUT_W] = res[OUT_W-1:0];
      res = zr - EW'(s3_pos_q[2]);
      out_d[(3*f+2)*OUT_W +: OUT_W] = res[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[3];
  assign out_data_o  = out_q;

endmodule

/* sv/dipole_field_rotate_translate_top.sv */
// Stages: one squaring stage, one square root cell per root bit, one divider cell per quotient bit,
// four rotation stages. Throughput: one item per cycle while the output is not stalled; every
// stage holds its own valid flag, so bubbles close up while the output is stalled.
// Reset (rst_ni low, asynchronous) empties every stage; no clearing pass is needed.
// Depends on dfrt_pkg, dfrt_sqrt_cell, dfrt_div_cell and dfrt_rotator.
module dipole_field_rotate_translate_top
  import dfrt_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int IN_WIDTH  = 24
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // dir_x, dir_y, dir_z, pos_x, pos_y, pos_z, e_x, e_y, e_z, h_x, h_y, h_z from bit 0
  input  logic [((N_IN*IN_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // e_out_x, e_out_y, e_out_z, h_out_x, h_out_y, h_out_z from bit 0
  output logic [OUT_TD-1:0]                        m_axis_tdata
);

  localparam int W       = IN_WIDTH;
  localparam int F       = FRAC_BITS;
  localparam int SW      = 2 * W;
  localparam int DV      = W + F + 1;
  localparam int QW      = F + 1;
  localparam int CW      = F + 2;
  localparam int SQ_SIDE = N_IN * W;
  localparam int REST_W  = 9 * W;
  localparam int FL_W    = N_RATIO * $bits(ratio_flag_t);
  localparam int DV_SIDE = FL_W + REST_W;

  // Squaring stage.
  logic                 sq_v_q;
  logic [SW-1:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [SQ_SIDE-1:0]   sq_side_q;
  logic signed [W-1:0]  in_dx, in_dy, in_dz;
  logic signed [SW-1:0] px, py, pz;

  // Square root chain.
  logic               s_v    [W+1];
  logic               s_r    [W+1];
  logic [SW-1:0]      s_nxy  [W+1];
  logic [SW-1:0]      s_rxy  [W+1];
  logic [SW-1:0]      s_nall [W+1];
  logic [SW-1:0]      s_rall [W+1];
  logic [SQ_SIDE-1:0] s_side [W+1];

  // Divider chain.
  logic               d_v    [F+2];
  logic               d_r    [F+2];
  logic [DV-1:0]      d_rem  [F+2][N_RATIO];
  logic [DV-1:0]      d_den  [F+2][N_RATIO];
  logic [QW-1:0]      d_q    [F+2][N_RATIO];
  logic [DV_SIDE-1:0] d_side [F+2];

  // Divider setup and quotient decode.
  logic [W-1:0]         nxy, nall;
  logic signed [W-1:0]  num [N_RATIO];
  logic [W-1:0]         den [N_RATIO];
  logic [W-1:0]         mag;
  logic [DV-1:0]        rem0 [N_RATIO];
  logic [DV-1:0]        den0 [N_RATIO];
  logic [QW-1:0]        q0   [N_RATIO];
  ratio_flag_t          fl_in  [N_RATIO];
  ratio_flag_t          fl_out [N_RATIO];
  logic [FL_W-1:0]      fl_pack;
  logic [FL_W-1:0]      fl_end;
  logic signed [CW-1:0] rt [N_RATIO];
  logic signed [CW-1:0] qs;

  assign in_dx = signed'(s_axis_tdata[0*W +: W]);
  assign in_dy = signed'(s_axis_tdata[1*W +: W]);
  assign in_dz = signed'(s_axis_tdata[2*W +: W]);
  assign px    = SW'(in_dx) * SW'(in_dx);
  assign py    = SW'(in_dy) * SW'(in_dy);
  assign pz    = SW'(in_dz) * SW'(in_dz);

  assign s_axis_tready = !sq_v_q || s_r[0];

  // Squares of the direction components.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      sq_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      sq_x_q    <= px;
      sq_y_q    <= py;
      sq_z_q    <= pz;
      sq_side_q <= s_axis_tdata[SQ_SIDE-1:0];
    end
  end

  assign s_v[0]    = sq_v_q;
  assign s_nxy[0]  = sq_x_q + sq_y_q;
  assign s_nall[0] = sq_x_q + sq_y_q + sq_z_q;
  assign s_rxy[0]  = '0;
  assign s_rall[0] = '0;
  assign s_side[0] = sq_side_q;

  // Square root cells, most significant root bit first.
  for (genvar k = 0; k < W; k++) begin : g_sqrt
    dfrt_sqrt_cell #(
      .SW     (SW),
      .STEP   (k),
      .SIDE_W (SQ_SIDE)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (s_v[k]),
      .in_ready_o  (s_r[k]),
      .n_xy_i      (s_nxy[k]),
      .r_xy_i      (s_rxy[k]),
      .n_all_i     (s_nall[k]),
      .r_all_i     (s_rall[k]),
      .side_i      (s_side[k]),
      .out_valid_o (s_v[k+1]),
      .out_ready_i (s_r[k+1]),
      .n_xy_o      (s_nxy[k+1]),
      .r_xy_o      (s_rxy[k+1]),
      .n_all_o     (s_nall[k+1]),
      .r_all_o     (s_rall[k+1]),
      .side_o      (s_side[k+1])
    );
  end

  // Divider setup: magnitude scaled up, plus half the divisor for rounding.
  assign nxy  = s_rxy[W][W-1:0];
  assign nall = s_rall[W][W-1:0];

  always_comb begin
    num[RT_CT] = signed'(s_side[W][2*W +: W]);
    num[RT_ST] = '0;
    num[RT_CP] = signed'(s_side[W][0 +: W]);
    num[RT_SP] = signed'(s_side[W][W +: W]);
    den[RT_CT] = nall;
    den[RT_ST] = nall;
    den[RT_CP] = nxy;
    den[RT_SP] = nxy;
    fl_pack    = '0;
    for (int i = 0; i < N_RATIO; i++) begin
      if (i == RT_ST) begin
        mag          = nxy;
        fl_in[i].neg = 1'b0;
      end else begin
        fl_in[i].neg = num[i][W-1];
        mag          = num[i][W-1] ? W'(-num[i]) : W'(num[i]);
      end
      fl_in[i].zero = (den[i] == '0);
      rem0[i]       = (DV'(mag) << F) + DV'(den[i] >> 1);
      den0[i]       = DV'(den[i]);
      q0[i]         = '0;
      fl_pack[i*$bits(ratio_flag_t) +: $bits(ratio_flag_t)] = fl_in[i];
    end
  end

  assign d_rem[0]  = rem0;
  assign d_den[0]  = den0;
  assign d_q[0]    = q0;
  assign d_v[0]    = s_v[W];
  assign s_r[W]    = d_r[0];
  assign d_side[0] = {fl_pack, s_side[W][SQ_SIDE-1:3*W]};

  // Divider cells, most significant quotient bit first.
  for (genvar k = 0; k <= F; k++) begin : g_div
    dfrt_div_cell #(
      .DV     (DV),
      .QW     (QW),
      .J      (F - k),
      .SIDE_W (DV_SIDE)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (d_v[k]),
      .in_ready_o  (d_r[k]),
      .rem_i       (d_rem[k]),
      .den_i       (d_den[k]),
      .q_i         (d_q[k]),
      .side_i      (d_side[k]),
      .out_valid_o (d_v[k+1]),
      .out_ready_i (d_r[k+1]),
      .rem_o       (d_rem[k+1]),
      .den_o       (d_den[k+1]),
      .q_o         (d_q[k+1]),
      .side_o      (d_side[k+1])
    );
  end

  // Signed ratios; a zero divisor gives cos 1 and sin 0.
  assign fl_end = d_side[F+1][DV_SIDE-1:REST_W];

  always_comb begin
    for (int i = 0; i < N_RATIO; i++) begin
      fl_out[i] = fl_end[i*$bits(ratio_flag_t) +: $bits(ratio_flag_t)];
      qs        = signed'(CW'(d_q[F+1][i]));
      if (fl_out[i].zero) begin
        rt[i] = (i == RT_CT || i == RT_CP) ? (CW'(1) <<< F) : '0;
      end else begin
        rt[i] = fl_out[i].neg ? -qs : qs;
      end
    end
  end

  dfrt_rotator #(
    .W (W),
    .F (F)
  ) u_rotator (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_v[F+1]),
    .in_ready_o  (d_r[F+1]),
    .ct_i        (rt[RT_CT]),
    .st_i        (rt[RT_ST]),
    .cp_i        (rt[RT_CP]),
    .sp_i        (rt[RT_SP]),
    .rest_i      (d_side[F+1][REST_W-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* sv/dfrt_checker.sv */
// Port-level checks for the dipole field rotate and translate block, bound to its top level.
// Depends on dfrt_pkg and dipole_field_rotate_translate_top.
module dfrt_checker
  import dfrt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_TD-1:0] m_axis_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // With the output free, every stage can move, so the input side is ready.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input not ready although the output is free");

  // No result can come out of an emptied pipeline in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result shown straight after reset");

endmodule

bind dipole_field_rotate_translate_top dfrt_checker u_dfrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_top.sv */
// Self-checking bench for dipole_field_rotate_translate_top: it streams field items,
// predicts each rotated and translated result and compares it with what comes out.
// Depends on dfrt_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top
  import dfrt_pkg::*;
();

  localparam int FB      = 16;
  localparam int IW      = 24;
  localparam int IN_TD   = ((N_IN * IW + 7) / 8) * 8;
  localparam int N_ITEMS = 550;
  localparam int STALL_LIMIT = 5000;

  typedef logic [N_OUT*OUT_W-1:0] field_set_t;

  // A pending transfer, or a marker that makes the sender wait for the pipeline to drain.
  typedef struct {
    logic           drain;
    logic [IN_TD-1:0] data;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TD-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TD-1:0] m_axis_tdata;

  stim_t      stim_q[$];
  field_set_t fields_due_q[$];
  int         n_sent = 0;
  int         n_checked = 0;
  int         n_errors = 0;
  int         idle_cycles = 0;
  int         n_zero_dir = 0;
  int         n_axial = 0;

  dipole_field_rotate_translate_top #(.FRAC_BITS(FB), .IN_WIDTH(IW)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Integer square root, rounded down.
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // num * 2^FB / den, rounded to nearest with ties away from zero.
  function automatic longint unit_ratio(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = ((mag << FB) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Arithmetic right shift with ties rounded towards +infinity.
  function automatic longint shift_round(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint field_of(logic [IN_TD-1:0] d, int idx);
    logic signed [IW-1:0] f;
    f = d[idx*IW +: IW];
    return longint'(f);
  endfunction

  // Rotated and translated E and H fields expected for one input item.
  function automatic field_set_t rotated_fields(logic [IN_TD-1:0] d);
    longint dv[3];
    longint pv[3];
    longint vv[3];
    longint unsigned sxy;
    longint unsigned nxy;
    longint unsigned nrm;
    longint ct, st, cp, sp, a, b, c, ox, oy, oz;
    field_set_t res;
    for (int i = 0; i < 3; i++) begin
      dv[i] = field_of(d, i);
      pv[i] = field_of(d, 3 + i);
    end
    sxy = dv[0] * dv[0] + dv[1] * dv[1];
    nxy = isqrt(sxy);
    nrm = isqrt(sxy + dv[2] * dv[2]);
    ct = longint'(1) << FB;
    st = 0;
    cp = longint'(1) << FB;
    sp = 0;
    if (nrm != 0) begin
      ct = unit_ratio(dv[2], nrm);
      st = unit_ratio(longint'(nxy), nrm);
    end
    if (nxy != 0) begin
      cp = unit_ratio(dv[0], nxy);
      sp = unit_ratio(dv[1], nxy);
    end
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < 3; i++) vv[i] = field_of(d, 6 + 3 * f + i);
      a = ct * vv[0] + st * vv[2];
      b = vv[1] <<< FB;
      c = ct * vv[2] - st * vv[0];
      ox = shift_round(cp * a - sp * b, 2 * FB) - pv[0];
      oy = shift_round(sp * a + cp * b, 2 * FB) - pv[1];
      oz = shift_round(c, FB) - pv[2];
      res[(3*f)*OUT_W +: OUT_W]   = ox[OUT_W-1:0];
      res[(3*f+1)*OUT_W +: OUT_W] = oy[OUT_W-1:0];
      res[(3*f+2)*OUT_W +: OUT_W] = oz[OUT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [IW-1:0] rand_field();
    return IW'($urandom);
  endfunction

  task automatic add_item(logic [IW-1:0] f[12]);
    stim_t s;
    s.drain = 1'b0;
    s.data = '0;
    for (int i = 0; i < 12; i++) s.data[i*IW +: IW] = f[i];
    if (f[0] == '0 && f[1] == '0) begin
      if (f[2] == '0) n_zero_dir++;
      else n_axial++;
    end
    stim_q.push_back(s);
  endtask

  task automatic add_drain();
    stim_t s;
    s.drain = 1'b1;
    s.data = '0;
    stim_q.push_back(s);
  endtask

  // Sender: one transfer at a time from the pending queue, idling at random.
  always @(posedge clk_i) begin
    stim_t cur;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (stim_q.size() != 0 && stim_q[0].drain) begin
        s_axis_tvalid <= 1'b0;
        if (!s_axis_tvalid && fields_due_q.size() == 0) void'(stim_q.pop_front());
      end else if (stim_q.size() != 0 &&
                   ((n_sent >= 150 && n_sent < 300) || $urandom_range(99) >= 17)) begin
        cur = stim_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur.data;
        n_sent++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: back-pressure at random, with a calm window.
  always @(posedge clk_i) begin
    if (rst_ni)
      m_axis_tready <= (n_checked >= 150 && n_checked < 300) || $urandom_range(99) >= 17;
  end

  // Monitor: record the expectation of each input transfer, check each result transfer.
  always @(posedge clk_i) begin
    field_set_t exp_f;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) fields_due_q.push_back(rotated_fields(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (fields_due_q.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time,
                   m_axis_tdata[N_OUT*OUT_W-1:0]);
          n_errors++;
        end else begin
          exp_f = fields_due_q.pop_front();
          for (int j = 0; j < N_OUT; j++) begin
            if (m_axis_tdata[j*OUT_W +: OUT_W] !== exp_f[j*OUT_W +: OUT_W]) begin
              $display("%0t: field %0d expected %h actual %h", $time, j,
                       exp_f[j*OUT_W +: OUT_W], m_axis_tdata[j*OUT_W +: OUT_W]);
              n_errors++;
            end
          end
          n_checked++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [IW-1:0] f[12];
    logic [IW-1:0] mx;
    logic [IW-1:0] mn;
    mx = {1'b0, {(IW-1){1'b1}}};
    mn = {1'b1, {(IW-1){1'b0}}};

    // Directed: zero direction, directions along each axis, extremes of every field.
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < 12; i++) f[i] = rand_field();
      case (k)
        0: for (int i = 0; i < 12; i++) f[i] = '0;
        1: begin
          f[0] = '0; f[1] = '0; f[2] = '0;
        end
        2: begin
          f[0] = '0; f[1] = '0; f[2] = mx;
        end
        3: begin
          f[0] = '0; f[1] = '0; f[2] = mn;
        end
        4: for (int i = 0; i < 12; i++) f[i] = mx;
        5: for (int i = 0; i < 12; i++) f[i] = mn;
        6: for (int i = 0; i < 12; i++) f[i] = (i % 2) ? mn : mx;
        7: for (int i = 0; i < 12; i++) f[i] = (i % 2) ? mx : mn;
        8: begin
          f[0] = mn; f[1] = mn; f[2] = mn;
        end
        9: begin
          f[0] = mx; f[1] = '0; f[2] = '0;
        end
        10: begin
          f[0] = '0; f[1] = mn; f[2] = '0;
        end
        11: begin
          f[0] = IW'(1); f[1] = '0; f[2] = '0;
        end
        12: begin
          f[0] = '1; f[1] = '1; f[2] = '1;
        end
        13: for (int i = 3; i < 12; i++) f[i] = '1;
        default: ;
      endcase
      add_item(f);
    end
    add_drain();

    // Random: mostly full range, some small or degenerate directions.
    for (int k = 0; k < N_ITEMS - 20; k++) begin
      for (int i = 0; i < 12; i++) f[i] = rand_field();
      case ($urandom_range(9))
        0: begin
          f[0] = '0; f[1] = '0;
        end
        1: begin
          f[0] = '0; f[1] = '0; f[2] = '0;
        end
        2: for (int i = 0; i < 3; i++) f[i] = IW'($signed($urandom_range(6)) - 3);
        default: ;
      endcase
      add_item(f);
      if (k == 260) add_drain();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(stim_q.size() == 0 && !s_axis_tvalid && fields_due_q.size() == 0))
      @(posedge clk_i);
    repeat (IW + FB + 20) @(posedge clk_i);

    $display("Streamed %0d field items (%0d zero and %0d axial directions), %0d results checked.",
             n_sent, n_zero_dir, n_axial, n_checked);
    if (n_errors == 0 && fields_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/dfrt_pkg.sv
sv/dfrt_sqrt_cell.sv
sv/dfrt_div_cell.sv
sv/dfrt_rotator.sv
sv/dipole_field_rotate_translate_top.sv
sv/dfrt_checker.sv
tb/tb_top.sv
